// ===== rtl/terminal_line_editor_assert.svh =====
// assertion macros for the terminal line editor
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// clocked check, masked while reset is asserted
`define TLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define TLE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/tle_pkg.sv =====
// shared types and constants of the terminal line editor
package tle_pkg;

	localparam int DEFAULT_LINE_CAPACITY = 32;
	localparam int LEN_W = 6;

	localparam logic [7:0] BYTE_NULL   = 8'h00;
	localparam logic [7:0] BYTE_BS     = 8'h08;
	localparam logic [7:0] BYTE_LF     = 8'h0A;
	localparam logic [7:0] BYTE_SPACE  = 8'h20;
	localparam logic [7:0] BYTE_PROMPT = 8'h3E;
	localparam logic [7:0] BYTE_DEL    = 8'h7F;
	localparam logic [7:0] BYTE_FF     = 8'hFF;

	localparam logic DEST_TERM   = 1'b0;
	localparam logic DEST_PARSER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BS1,
		ST_BS2,
		ST_BS3,
		ST_CHAR,
		ST_LINE,
		ST_NL,
		ST_PROMPT
	} seq_state_t;

	// one result handed from the sequencer to the output register
	typedef struct packed {
		logic       valid;
		logic       dest;
		logic [7:0] data;
		logic       last;
	} emit_t;

endpackage

// ===== rtl/tle_ram.sv =====
// generic simple dual-port ram with registered read
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tle_seq.sv =====
// editing sequencer: decodes bytes, keeps the length, walks the line memory
module tle_seq import tle_pkg::*; #(
	parameter int LINE_CAPACITY = DEFAULT_LINE_CAPACITY,
	parameter int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              parser_present,
	input  logic              out_free,
	output emit_t             emit,
	output logic              ram_we,
	output logic [ADDR_W-1:0] ram_waddr,
	output logic [7:0]        ram_wdata,
	output logic              ram_re,
	output logic [ADDR_W-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata
);

	localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

	seq_state_t state_q, state_d;
	logic [LEN_W-1:0] len_q, idx_q, idx_nxt;
	// length of the line being sent is held here since len_q clears on accept
	logic [LEN_W-1:0] send_len_q;
	logic [7:0] ch_q;
	logic accept, is_skip, is_bs, is_lf, has_room, line_done, line_step;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign has_room  = (len_q < CAP);
	assign line_done = (idx_q == send_len_q);
	assign idx_nxt   = idx_q + LEN_W'(1);
	assign line_step = (state_q == ST_LINE) && out_free && !line_done;

	always_comb begin
		is_skip = 1'b0;
		is_bs   = 1'b0;
		is_lf   = 1'b0;
		case (in_byte) inside
			BYTE_NULL, BYTE_FF: is_skip = 1'b1;
			BYTE_BS, BYTE_DEL:  is_bs = 1'b1;
			BYTE_LF:            is_lf = 1'b1;
			default:            ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_skip) begin
						state_d = ST_IDLE;
					end else if (is_bs) begin
						state_d = (len_q != '0) ? ST_BS1 : ST_IDLE;
					end else if (is_lf) begin
						state_d = parser_present ? ST_LINE : ST_NL;
					end else begin
						state_d = has_room ? ST_CHAR : ST_IDLE;
					end
				end
			end
			ST_BS1:    if (out_free) state_d = ST_BS2;
			ST_BS2:    if (out_free) state_d = ST_BS3;
			ST_BS3:    if (out_free) state_d = ST_IDLE;
			ST_CHAR:   if (out_free) state_d = ST_IDLE;
			ST_LINE:   if (out_free && line_done) state_d = ST_NL;
			ST_NL:     if (out_free) state_d = ST_PROMPT;
			ST_PROMPT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		emit       = '0;
		emit.dest  = DEST_TERM;
		ram_we     = accept && !is_skip && !is_bs && !is_lf && has_room;
		ram_waddr  = len_q[ADDR_W-1:0];
		ram_wdata  = in_byte;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		case (state_q)
			ST_IDLE: begin
				// prefetch the first entry with the line feed request
				ram_re = accept && is_lf;
			end
			ST_BS1: begin
				emit.valid = out_free;
				emit.data  = BYTE_BS;
			end
			ST_BS2: begin
				emit.valid = out_free;
				emit.data  = BYTE_SPACE;
			end
			ST_BS3: begin
				emit.valid = out_free;
				emit.data  = BYTE_BS;
				emit.last  = 1'b1;
			end
			ST_CHAR: begin
				emit.valid = out_free;
				emit.data  = ch_q;
				emit.last  = 1'b1;
			end
			ST_LINE: begin
				emit.valid = out_free;
				emit.dest  = DEST_PARSER;
				emit.data  = line_done ? 8'h00 : ram_rdata;
				// fetch the following entry as this one leaves
				ram_re     = line_step && (idx_nxt < send_len_q);
				ram_raddr  = idx_nxt[ADDR_W-1:0];
			end
			ST_NL: begin
				emit.valid = out_free;
				emit.data  = BYTE_LF;
			end
			ST_PROMPT: begin
				emit.valid = out_free;
				emit.data  = BYTE_PROMPT;
				emit.last  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			idx_q      <= '0;
			send_len_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && is_bs && (len_q != '0)) begin
				len_q <= len_q - LEN_W'(1);
			end else if (ram_we) begin
				len_q <= len_q + LEN_W'(1);
			end else if (accept && is_lf) begin
				len_q <= '0;
			end
			if (accept && is_lf) begin
				idx_q      <= '0;
				send_len_q <= len_q;
			end else if (line_step) begin
				idx_q <= idx_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= in_byte;
		end
	end

endmodule

// ===== rtl/terminal_line_editor.sv =====
// top level of the terminal line editor: sequencer, line memory, output register
// an input request is taken whenever the sequencer is idle
// ordinary byte: stored and echoed if the line has room; backspace: BS, space, BS if not empty
// line feed: stored characters and a zero byte to the parser if present, then LF and prompt
// one memory read a cycle while the output register is free; m_tready low stalls each sequence
// reset: length 0, parser_present 1, output empty; line memory is not cleared
module terminal_line_editor import tle_pkg::*; #(
	parameter int LINE_CAPACITY = DEFAULT_LINE_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	// rx request: [7:0] rx_byte
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	// result: tdata [7:0] out_byte, tuser [0] dest, tlast last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast,
	// parser_present register write
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	`include "terminal_line_editor_assert.svh"

	localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	emit_t emit;
	logic out_free;
	logic parser_q;
	logic m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic m_tuser_q, m_tlast_q;

	// line memory ports
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	// the output register can take a new result when empty or being drained
	assign out_free = !m_tvalid_q || m_tready;

	tle_seq #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.ADDR_W(ADDR_W)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.parser_present(parser_q),
		.out_free(out_free),
		.emit(emit),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// line characters, written at the tail, read in order on line feed
	tle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY),
		.ADDR_W(ADDR_W)
	) u_line_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration register; to be written only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parser_q <= 1'b1;
		end else if (cfg_we) begin
			parser_q <= cfg_wdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			m_tdata_q <= emit.data;
			m_tuser_q <= emit.dest;
			m_tlast_q <= emit.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// a result is only produced when the output register has room
	`TLE_ASSERT(a_emit_room, emit.valid |-> (!m_tvalid || m_tready), "result overran output")
	// while taking requests the sequencer has nothing left to send
	`TLE_ASSERT(a_idle_quiet, s_tready |-> !emit.valid, "result produced while idle")
	// output register empty during reset
	`TLE_ASSERT_RST(a_rst_empty, !arst_n |-> !m_tvalid, "output valid during reset")

endmodule
